// ===== rtl/core/ubxp_pkg.sv =====
// Shared types and constants for the frame parser.
`default_nettype none
package ubxp_pkg;

  localparam int CfgIdxW = 2;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SYNC_FIRST  = 2'd0;
  localparam cfg_idx_t CFG_SYNC_SECOND = 2'd1;
  localparam cfg_idx_t CFG_MAX_PAYLOAD = 2'd2;

  localparam logic [7:0]  RST_SYNC_FIRST  = 8'd181;
  localparam logic [7:0]  RST_SYNC_SECOND = 8'd98;
  localparam logic [15:0] RST_MAX_PAYLOAD = 16'd512;

  typedef logic [2:0] event_t;

  localparam event_t EV_NONE     = 3'd0;
  localparam event_t EV_PAYLOAD  = 3'd1;
  localparam event_t EV_GOOD     = 3'd2;
  localparam event_t EV_CK_A_BAD = 3'd3;
  localparam event_t EV_CK_B_BAD = 3'd4;
  localparam event_t EV_TOO_LONG = 3'd5;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_payload;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/ubxp_in_reg.sv =====
// Input register stage holding one received byte.
`default_nettype none
module ubxp_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       take,
  output logic            byte_valid,
  output logic [7:0]      byte_data
);

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_ready   = !valid_r || take;
  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      byte_r <= in_rx_byte;
    end
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !take |=> valid_r && $stable(byte_r))
    else $error("held byte lost before it was taken");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/ubxp_engine.sv =====
// Per-byte frame state machine, Fletcher sums and result register.
`default_nettype none
module ubxp_engine
  import ubxp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        byte_valid,
  input  wire logic [7:0]  byte_data,
  output logic             take,
  output logic             out_valid,
  input  wire logic        out_ready,
  output event_t           out_event_res,
  output logic [7:0]       out_frame_class,
  output logic [7:0]       out_frame_id,
  output logic [15:0]      out_frame_length,
  output logic [15:0]      out_payload_offset,
  output logic [7:0]       out_payload_value
);

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  event_t      ev_nxt;
  logic [15:0] off_nxt;
  logic [7:0]  val_nxt;

  logic        out_valid_r;
  event_t      out_event_r;
  logic [7:0]  out_class_r;
  logic [7:0]  out_id_r;
  logic [15:0] out_len_r;
  logic [15:0] out_off_r;
  logic [7:0]  out_val_r;

  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] len_full;
  logic [15:0] cnt_inc;
  phase_t      hunt;

  assign take = byte_valid && (!out_valid_r || out_ready);

  assign add_a    = sum_a_r + byte_data;
  assign add_b    = sum_b_r + add_a;
  assign len_full = {byte_data, len_r[7:0]};
  assign cnt_inc  = cnt_r + 16'd1;
  assign hunt     = (byte_data == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;

  always_comb begin
    phase_nxt = phase_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    class_nxt = class_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    ev_nxt    = EV_NONE;
    off_nxt   = 16'd0;
    val_nxt   = 8'd0;
    case (phase_r)
      PH_SYNC2: begin
        phase_nxt = (byte_data == cfg.sync_second) ? PH_CLASS : hunt;
      end
      PH_CLASS: begin
        class_nxt = byte_data;
        id_nxt    = 8'd0;
        len_nxt   = 16'd0;
        sum_a_nxt = byte_data;
        sum_b_nxt = byte_data;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_nxt    = byte_data;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt   = {8'd0, byte_data};
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt   = len_full;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        cnt_nxt   = 16'd0;
        if (len_full > cfg.max_payload) begin
          ev_nxt    = EV_TOO_LONG;
          phase_nxt = hunt;
        end else if (len_full == 16'd0) begin
          phase_nxt = PH_CK_A;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        ev_nxt    = EV_PAYLOAD;
        off_nxt   = cnt_r;
        val_nxt   = byte_data;
        cnt_nxt   = cnt_inc;
        if (cnt_inc == len_r) begin
          phase_nxt = PH_CK_A;
        end
      end
      PH_CK_A: begin
        if (byte_data == sum_a_r) begin
          phase_nxt = PH_CK_B;
        end else begin
          ev_nxt    = EV_CK_A_BAD;
          phase_nxt = hunt;
        end
      end
      PH_CK_B: begin
        if (byte_data == sum_b_r) begin
          ev_nxt    = EV_GOOD;
          phase_nxt = PH_SYNC1;
        end else begin
          ev_nxt    = EV_CK_B_BAD;
          phase_nxt = hunt;
        end
      end
      default: begin
        phase_nxt = hunt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC1;
      sum_a_r     <= 8'd0;
      sum_b_r     <= 8'd0;
      class_r     <= 8'd0;
      id_r        <= 8'd0;
      len_r       <= 16'd0;
      cnt_r       <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt;
        sum_a_r <= sum_a_nxt;
        sum_b_r <= sum_b_nxt;
        class_r <= class_nxt;
        id_r    <= id_nxt;
        len_r   <= len_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (take) begin
      out_event_r <= ev_nxt;
      out_class_r <= class_nxt;
      out_id_r    <= id_nxt;
      out_len_r   <= len_nxt;
      out_off_r   <= off_nxt;
      out_val_r   <= val_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = out_event_r;
  assign out_frame_class    = out_class_r;
  assign out_frame_id       = out_id_r;
  assign out_frame_length   = out_len_r;
  assign out_payload_offset = out_off_r;
  assign out_payload_value  = out_val_r;

`ifndef ASSERT_OFF
  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> cnt_r < len_r)
    else $error("payload count reached frame length inside payload");
  a_off_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_event_r == EV_PAYLOAD |-> out_off_r < out_len_r)
    else $error("payload offset beyond frame length");
  a_non_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_event_r != EV_PAYLOAD |-> out_off_r == 16'd0 && out_val_r == 8'd0)
    else $error("offset or value set on a non-payload event");
  a_good_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_event_r == EV_GOOD |-> phase_r == PH_SYNC1)
    else $error("good frame did not return to sync hunt");
  a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_event_r == EV_PAYLOAD |-> phase_r == PH_PAYLOAD || phase_r == PH_CK_A)
    else $error("payload event outside payload phase");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/ubx_frame_parser_core.sv =====
// Top level of the binary navigation frame parser with Fletcher-8 check.
//
// Usage: one received byte per item on in_rx_byte (valid/ready). Every
// accepted byte yields exactly one result item on the out_ channel: an
// event code plus the class, id and length held for the current frame,
// and for payload bytes the offset and value.
// Path: an accepted byte sits in the input register, is parsed into the
// result register when the engine takes it and then shows on the out_
// channel. Throughput: one byte per cycle while out_ready is high; the
// state machine and both 8-bit Fletcher adders sit in the single stage
// between the two registers.
// Stall: when out_ready is low the result register holds, the input
// register fills, then in_ready drops; nothing is lost or repeated.
// Configuration: cfg_we writes register cfg_index (0 first sync byte,
// 1 second sync byte, 2 max payload length) with cfg_wdata, to be done
// only while no item is in flight. Other indexes are ignored.
// Reset (rst_n low, synchronous): both stages empty, parser hunting for
// the first sync byte, sums and held fields zero, registers to defaults.
`default_nettype none
module ubx_frame_parser_core
  import ubxp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [15:0]       cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_rx_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_event_res,
  output logic [7:0]             out_frame_class,
  output logic [7:0]             out_frame_id,
  output logic [15:0]            out_frame_length,
  output logic [15:0]            out_payload_offset,
  output logic [7:0]             out_payload_value
);

  cfg_t       cfg_r;
  logic       take;
  logic       byte_valid;
  logic [7:0] byte_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= RST_SYNC_FIRST;
      cfg_r.sync_second <= RST_SYNC_SECOND;
      cfg_r.max_payload <= RST_MAX_PAYLOAD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  cfg_r.sync_first  <= cfg_wdata[7:0];
        CFG_SYNC_SECOND: cfg_r.sync_second <= cfg_wdata[7:0];
        CFG_MAX_PAYLOAD: cfg_r.max_payload <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ubxp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  ubxp_engine u_engine (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .byte_valid         (byte_valid),
    .byte_data          (byte_data),
    .take               (take),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_frame_class    (out_frame_class),
    .out_frame_id       (out_frame_id),
    .out_frame_length   (out_frame_length),
    .out_payload_offset (out_payload_offset),
    .out_payload_value  (out_payload_value)
  );

endmodule
`default_nettype wire

// ===== verif/ubx_frame_checker.sv =====
// Watches the frame parser's byte and result channels, predicts each result and compares.
`timescale 1ns / 1ps
module ubx_frame_checker
  import ubxp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [7:0]         in_rx_byte,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [2:0]         out_event_res,
  input  wire logic [7:0]         out_frame_class,
  input  wire logic [7:0]         out_frame_id,
  input  wire logic [15:0]        out_frame_length,
  input  wire logic [15:0]        out_payload_offset,
  input  wire logic [7:0]         out_payload_value,
  output int                      n_errors,
  output int                      n_pending,
  output int                      n_checked,
  output int                      n_frames_ok,
  output int                      n_frames_bad
);

  typedef enum logic [3:0] {
    PH_HUNT, PH_SYNC2, PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_CK_A, PH_CK_B
  } parse_phase_t;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] len;
    logic [15:0] off;
    logic [7:0]  val;
  } frame_event_t;

  cfg_t         cfg;
  parse_phase_t phase;
  logic [7:0]   sum_a;
  logic [7:0]   sum_b;
  logic [7:0]   held_class;
  logic [7:0]   held_id;
  logic [15:0]  held_length;
  logic [15:0]  byte_count;
  frame_event_t expected_q[$];
  frame_event_t expected_item;

  function automatic parse_phase_t hunt_phase(input logic [7:0] b);
    return (b == cfg.sync_first) ? PH_SYNC2 : PH_HUNT;
  endfunction

  function automatic void add_to_sums(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endfunction

  function automatic frame_event_t parse_byte(input logic [7:0] b);
    frame_event_t r;
    r = '0;
    r.ev = EV_NONE;
    case (phase)
      PH_SYNC2: begin
        if (b == cfg.sync_second) phase = PH_CLASS;
        else phase = hunt_phase(b);
      end
      PH_CLASS: begin
        held_class = b;
        held_id = '0;
        held_length = '0;
        sum_a = b;
        sum_b = b;
        phase = PH_ID;
      end
      PH_ID: begin
        held_id = b;
        add_to_sums(b);
        phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        held_length = {8'h00, b};
        add_to_sums(b);
        phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        held_length[15:8] = b;
        add_to_sums(b);
        byte_count = '0;
        if (held_length > cfg.max_payload) begin
          r.ev = EV_TOO_LONG;
          phase = hunt_phase(b);
        end else if (held_length == 16'd0) begin
          phase = PH_CK_A;
        end else begin
          phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        add_to_sums(b);
        r.ev = EV_PAYLOAD;
        r.off = byte_count;
        r.val = b;
        byte_count = byte_count + 16'd1;
        if (byte_count == held_length) phase = PH_CK_A;
      end
      PH_CK_A: begin
        if (b == sum_a) begin
          phase = PH_CK_B;
        end else begin
          r.ev = EV_CK_A_BAD;
          phase = hunt_phase(b);
        end
      end
      PH_CK_B: begin
        if (b == sum_b) begin
          r.ev = EV_GOOD;
          phase = PH_HUNT;
        end else begin
          r.ev = EV_CK_B_BAD;
          phase = hunt_phase(b);
        end
      end
      default: phase = hunt_phase(b);
    endcase
    r.cls = held_class;
    r.id = held_id;
    r.len = held_length;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got_val,
                                 input logic [15:0] exp_val);
    $display("ERROR: result %0d %s: got 0x%0h, expected 0x%0h",
             n_checked, what, got_val, exp_val);
    n_errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg.sync_first = RST_SYNC_FIRST;
      cfg.sync_second = RST_SYNC_SECOND;
      cfg.max_payload = RST_MAX_PAYLOAD;
      phase = PH_HUNT;
      sum_a = '0;
      sum_b = '0;
      held_class = '0;
      held_id = '0;
      held_length = '0;
      byte_count = '0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("event with no byte pending", 16'(out_event_res), 16'(EV_NONE));
        end else begin
          expected_item = expected_q.pop_front();
          if (out_event_res !== expected_item.ev)
            report_mismatch("event", 16'(out_event_res), 16'(expected_item.ev));
          if (out_frame_class !== expected_item.cls)
            report_mismatch("class", 16'(out_frame_class), 16'(expected_item.cls));
          if (out_frame_id !== expected_item.id)
            report_mismatch("id", 16'(out_frame_id), 16'(expected_item.id));
          if (out_frame_length !== expected_item.len)
            report_mismatch("length", out_frame_length, expected_item.len);
          if (out_payload_offset !== expected_item.off)
            report_mismatch("payload offset", out_payload_offset, expected_item.off);
          if (out_payload_value !== expected_item.val)
            report_mismatch("payload value", 16'(out_payload_value), 16'(expected_item.val));
          if (expected_item.ev == EV_GOOD) n_frames_ok++;
          if (expected_item.ev == EV_CK_A_BAD || expected_item.ev == EV_CK_B_BAD ||
              expected_item.ev == EV_TOO_LONG) n_frames_bad++;
        end
        n_checked++;
      end
      if (in_valid && in_ready) expected_q.push_back(parse_byte(in_rx_byte));
      if (cfg_we) begin
        case (cfg_index)
          CFG_SYNC_FIRST:  cfg.sync_first = cfg_wdata[7:0];
          CFG_SYNC_SECOND: cfg.sync_second = cfg_wdata[7:0];
          CFG_MAX_PAYLOAD: cfg.max_payload = cfg_wdata;
          default: ;
        endcase
      end
    end
    n_pending = expected_q.size();
  end

endmodule

// ===== verif/tb_ubx_frame_parser_core.sv =====
// Testbench top for the frame parser: clock, reset, byte and register stimulus, verdict.
`timescale 1ns / 1ps
module tb_ubx_frame_parser_core;
  import ubxp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [1:0] {FR_GOOD, FR_BAD_A, FR_BAD_B, FR_TOO_LONG} frame_fault_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_index = CFG_SYNC_FIRST;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_rx_byte = '0;
  logic        out_ready = 1'b0;
  wire         in_ready;
  wire         out_valid;
  wire [2:0]   out_event_res;
  wire [7:0]   out_frame_class;
  wire [7:0]   out_frame_id;
  wire [15:0]  out_frame_length;
  wire [15:0]  out_payload_offset;
  wire [7:0]   out_payload_value;

  int n_errors;
  int n_pending;
  int n_checked;
  int n_frames_ok;
  int n_frames_bad;
  int n_sent;
  int cycles;

  logic        idle_on = 1'b1;
  logic [7:0]  cur_sync1 = RST_SYNC_FIRST;
  logic [7:0]  cur_sync2 = RST_SYNC_SECOND;
  logic [15:0] cur_max = RST_MAX_PAYLOAD;

  always #2 clk = ~clk;

  ubx_frame_parser_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_frame_class    (out_frame_class),
    .out_frame_id       (out_frame_id),
    .out_frame_length   (out_frame_length),
    .out_payload_offset (out_payload_offset),
    .out_payload_value  (out_payload_value)
  );

  ubx_frame_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_frame_class    (out_frame_class),
    .out_frame_id       (out_frame_id),
    .out_frame_length   (out_frame_length),
    .out_payload_offset (out_payload_offset),
    .out_payload_value  (out_payload_value),
    .n_errors           (n_errors),
    .n_pending          (n_pending),
    .n_checked          (n_checked),
    .n_frames_ok        (n_frames_ok),
    .n_frames_bad       (n_frames_bad)
  );

  always @(negedge clk) begin
    out_ready = !idle_on || ($urandom_range(0, 99) >= 21);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycles, n_pending);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 21) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  // sync, header, payload, Fletcher checks (one spoiled if asked); too long: header only
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input frame_fault_t fault);
    logic [7:0] hdr [4];
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    logic [7:0] pb;
    int i;
    hdr[0] = cls;
    hdr[1] = id;
    hdr[2] = len[7:0];
    hdr[3] = len[15:8];
    ck_a = '0;
    ck_b = '0;
    send_byte(cur_sync1);
    send_byte(cur_sync2);
    for (i = 0; i < 4; i++) begin
      ck_a = ck_a + hdr[i];
      ck_b = ck_b + ck_a;
      send_byte(hdr[i]);
    end
    if (fault == FR_TOO_LONG) return;
    for (i = 0; i < int'(len); i++) begin
      pb = 8'($urandom);
      ck_a = ck_a + pb;
      ck_b = ck_b + ck_a;
      send_byte(pb);
    end
    // a spoiled check byte is a sync byte where possible, so it restarts a hunt
    if (fault == FR_BAD_A) begin
      send_byte((cur_sync1 != ck_a) ? cur_sync1 : ~ck_a);
      return;
    end
    send_byte(ck_a);
    if (fault == FR_BAD_B) send_byte((cur_sync1 != ck_b) ? cur_sync1 : ~ck_b);
    else send_byte(ck_b);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] s1, input logic [7:0] s2,
                            input logic [15:0] max_len);
    drain();
    cfg_we = 1'b1;
    cfg_index = CFG_SYNC_FIRST;
    cfg_wdata = {8'h00, s1};
    @(negedge clk);
    cfg_index = CFG_SYNC_SECOND;
    cfg_wdata = {8'h00, s2};
    @(negedge clk);
    cfg_index = CFG_MAX_PAYLOAD;
    cfg_wdata = max_len;
    @(negedge clk);
    cfg_we = 1'b0;
    cur_sync1 = s1;
    cur_sync2 = s2;
    cur_max = max_len;
  endtask

  task automatic send_random_traffic(input int n_bytes);
    int stop_at;
    int r;
    int k;
    logic [15:0] len;
    frame_fault_t fault;
    stop_at = n_sent + n_bytes;
    while (n_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        r = $urandom_range(0, 99);
        fault = (r < 76) ? FR_GOOD : (r < 86) ? FR_BAD_A : (r < 95) ? FR_BAD_B : FR_TOO_LONG;
        if (fault == FR_TOO_LONG && cur_max == 16'hFFFF) fault = FR_GOOD;
        if (fault == FR_TOO_LONG) begin
          if ($urandom_range(0, 1) == 0) len = cur_max + 16'd1;
          else len = 16'($urandom_range(65535, int'(cur_max) + 1));
        end else if ($urandom_range(0, 9) == 0) begin
          len = (cur_max > 16'd40) ? 16'd40 : cur_max;
        end else begin
          len = 16'($urandom_range(0, (cur_max < 16'd12) ? int'(cur_max) : 12));
        end
        send_frame(8'($urandom), 8'($urandom), len, fault);
      end else begin
        k = $urandom_range(1, 4);
        repeat (k) send_byte(($urandom_range(0, 99) < 20) ? cur_sync1 : 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] s;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: noise, a doubled first sync, empty payload, each error kind
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cur_sync1);
    send_frame(8'hFF, 8'h00, 16'd0, FR_GOOD);
    send_frame(8'h00, 8'hFF, 16'd1, FR_BAD_A);
    send_frame(8'h5A, 8'hA5, 16'hB500, FR_TOO_LONG);
    send_frame(8'h01, 8'h80, 16'd0, FR_BAD_B);
    send_frame(8'h06, 8'h01, 16'd3, FR_GOOD);

    send_random_traffic(120);

    set_config(8'h00, 8'hFF, 16'h0000);
    send_random_traffic(80);

    set_config(8'hFF, 8'h00, 16'hFFFF);
    idle_on = 1'b0;
    send_random_traffic(90);
    idle_on = 1'b1;

    s = 8'($urandom);
    set_config(s, s, 16'($urandom_range(1, 40)));
    send_random_traffic(70);

    set_config(8'($urandom), 8'($urandom), 16'($urandom));
    send_random_traffic(70);

    drain();
    $display("Sent %0d bytes over five register settings; checked %0d results,", n_sent,
             n_checked);
    $display("%0d frames with good checks and %0d rejected frames.", n_frames_ok, n_frames_bad);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
